### design/ppmfd_pkg.sv
// Shared types and constants for the PPM frame decoder.
package ppmfd_pkg;

   // Number of channels in one frame, 5 to 15.
   localparam logic [3:0] CHANNELS = 4'd9;

   localparam int IDX_W        = 4;
   localparam int ADDR_W       = IDX_W + 1;
   localparam int BANK_ENTRIES = 2 ** ADDR_W;

   // Configuration reset values.
   localparam logic [15:0] SYNC_MIN_RST    = 16'd3500;
   localparam logic [15:0] SYNC_MAX_RST    = 16'd13500;
   localparam logic [15:0] PULSE_MIN_RST   = 16'd900;
   localparam logic [15:0] PULSE_MAX_RST   = 16'd2100;
   localparam logic [15:0] SCALE_LOW_RST   = 16'd1100;
   localparam logic [15:0] SCALE_SPAN_RST  = 16'd800;
   localparam logic [7:0]  FAIL_LEVEL_RST  = 8'd140;
   localparam logic [7:0]  ERROR_LIMIT_RST = 8'd8;

   typedef struct packed {
      logic [15:0] sync_min;
      logic [15:0] sync_max;
      logic [15:0] pulse_min;
      logic [15:0] pulse_max;
      logic [15:0] scale_low;
      logic [15:0] scale_span;
      logic [7:0]  fail_level;
      logic [7:0]  error_limit;
   } cfg_type;

   typedef struct packed {
      logic [3:0] channel_index;
      logic [7:0] channel_value;
      logic       value_written;
      logic       frame_swapped;
      logic       link_ok;
      logic       beep;
      logic [7:0] pitch_raw;
      logic [7:0] roll_raw;
      logic [7:0] force_raw;
      logic [7:0] yaw_raw;
      logic       motors_on;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic        start;
      logic [23:0] num;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quot;
   } div_rsp_type;

endpackage

### design/ppmfd_csr.sv
// Configuration register file with APB-style access.
module ppmfd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output ppmfd_pkg::cfg_type  cfg
);
   import ppmfd_pkg::*;

   localparam logic [2:0] REG_SYNC_MIN    = 3'd0;
   localparam logic [2:0] REG_SYNC_MAX    = 3'd1;
   localparam logic [2:0] REG_PULSE_MIN   = 3'd2;
   localparam logic [2:0] REG_PULSE_MAX   = 3'd3;
   localparam logic [2:0] REG_SCALE_LOW   = 3'd4;
   localparam logic [2:0] REG_SCALE_SPAN  = 3'd5;
   localparam logic [2:0] REG_FAIL_LEVEL  = 3'd6;
   localparam logic [2:0] REG_ERROR_LIMIT = 3'd7;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx = csr_paddr[4:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_min    <= SYNC_MIN_RST;
         cfg_ff.sync_max    <= SYNC_MAX_RST;
         cfg_ff.pulse_min   <= PULSE_MIN_RST;
         cfg_ff.pulse_max   <= PULSE_MAX_RST;
         cfg_ff.scale_low   <= SCALE_LOW_RST;
         cfg_ff.scale_span  <= SCALE_SPAN_RST;
         cfg_ff.fail_level  <= FAIL_LEVEL_RST;
         cfg_ff.error_limit <= ERROR_LIMIT_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SYNC_MIN:    cfg_ff.sync_min    <= csr_pwdata[15:0];
            REG_SYNC_MAX:    cfg_ff.sync_max    <= csr_pwdata[15:0];
            REG_PULSE_MIN:   cfg_ff.pulse_min   <= csr_pwdata[15:0];
            REG_PULSE_MAX:   cfg_ff.pulse_max   <= csr_pwdata[15:0];
            REG_SCALE_LOW:   cfg_ff.scale_low   <= csr_pwdata[15:0];
            REG_SCALE_SPAN:  cfg_ff.scale_span  <= csr_pwdata[15:0];
            REG_FAIL_LEVEL:  cfg_ff.fail_level  <= csr_pwdata[7:0];
            REG_ERROR_LIMIT: cfg_ff.error_limit <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SYNC_MIN:    csr_prdata = {16'd0, cfg_ff.sync_min};
         REG_SYNC_MAX:    csr_prdata = {16'd0, cfg_ff.sync_max};
         REG_PULSE_MIN:   csr_prdata = {16'd0, cfg_ff.pulse_min};
         REG_PULSE_MAX:   csr_prdata = {16'd0, cfg_ff.pulse_max};
         REG_SCALE_LOW:   csr_prdata = {16'd0, cfg_ff.scale_low};
         REG_SCALE_SPAN:  csr_prdata = {16'd0, cfg_ff.scale_span};
         REG_FAIL_LEVEL:  csr_prdata = {24'd0, cfg_ff.fail_level};
         REG_ERROR_LIMIT: csr_prdata = {24'd0, cfg_ff.error_limit};
         default:         csr_prdata = 32'd0;
      endcase
   end

endmodule

### design/ppmfd_bank_mem.sv
// Two channel banks in one synchronous RAM, entries read as zero until written.
module ppmfd_bank_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  ppmfd_pkg::mem_req_type mem_req,
   output logic [7:0]             rd_data
);
   import ppmfd_pkg::*;

   logic [7:0]              ram_ff [BANK_ENTRIES];
   logic [BANK_ENTRIES-1:0] valid_ff;
   logic [7:0]              data_ff;
   logic                    hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ram_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         data_ff <= ram_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            hit_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : 8'd0;

endmodule

### design/ppmfd_div.sv
// Restoring divider producing an 8-bit quotient, one bit per cycle.
module ppmfd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  ppmfd_pkg::div_req_type div_req,
   output ppmfd_pkg::div_rsp_type div_rsp
);
   import ppmfd_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [2:0]  step_ff;
   logic [15:0] rem_ff;
   logic [15:0] divisor_ff;
   logic [7:0]  low_ff;
   logic [7:0]  quot_ff;
   logic [16:0] trial;
   logic        ge;

   // Numerator is below 256 * divisor, so the upper 16 bits start below the divisor.
   assign trial = {rem_ff, low_ff[7]};
   assign ge    = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            step_ff    <= '0;
            rem_ff     <= div_req.num[23:8];
            low_ff     <= div_req.num[7:0];
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff  <= ge ? 16'(trial - {1'b0, divisor_ff}) : trial[15:0];
            low_ff  <= {low_ff[6:0], 1'b0};
            quot_ff <= {quot_ff[6:0], ge};
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### design/ppmfd_seq.sv
// Sequencer: classifies each word, walks the bank RAM and builds the result.
module ppmfd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ppmfd_pkg::cfg_type     cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [15:0]            req_width,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppmfd_pkg::rsp_type     rsp_data,
   output ppmfd_pkg::mem_req_type mem_req,
   input  logic [7:0]             mem_rd_data,
   output ppmfd_pkg::div_req_type div_req,
   input  ppmfd_pkg::div_rsp_type div_rsp
);
   import ppmfd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCALE,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_SAFE_RD,
      ST_SAFE_CHK,
      ST_STICK_RD,
      ST_STICK_CHK,
      ST_MOTOR,
      ST_DONE
   } state_type;

   localparam logic [3:0] SAFE_FIRST  = 4'd4;
   localparam logic [3:0] SAFE_LAST   = 4'd8;
   localparam logic [3:0] STICK_LAST  = 4'd3;
   localparam logic [1:0] STICK_PITCH = 2'd0;
   localparam logic [1:0] STICK_ROLL  = 2'd1;
   localparam logic [1:0] STICK_FORCE = 2'd2;
   localparam logic [1:0] STICK_YAW   = 2'd3;
   localparam logic       REQ_POLL    = 1'b1;

   localparam logic [7:0] STICK_CENTER   = 8'd128;
   localparam logic [7:0] FORCE_FALLBACK = 8'd0;
   localparam logic [7:0] FORCE_IDLE_MAX = 8'd5;
   localparam logic [7:0] YAW_ARM_MAX    = 8'd45;
   localparam logic [7:0] YAW_DISARM_MIN = 8'd210;
   localparam logic [7:0] VALUE_MAX      = 8'd255;
   localparam logic [7:0] ERR_MAX        = 8'd255;

   state_type        state_ff;
   logic             bank_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [7:0]       err_ff;
   logic             link_ff;
   logic             motor_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          res_ff;
   logic             type_ff;
   logic [15:0]      width_ff;
   logic [IDX_W-1:0] k_ff;
   logic [7:0]       val_ff;
   logic [15:0]      d_ff;

   logic        is_sync;
   logic        is_chan;
   logic        below_low;
   logic        above_top;
   logic [16:0] scale_top;
   logic [7:0]  err_inc;
   logic        force_idle;
   rsp_type     rsp_data_in;

   assign scale_top = {1'b0, cfg.scale_low} + {1'b0, cfg.scale_span};
   assign is_sync   = (width_ff > cfg.sync_min) && (width_ff < cfg.sync_max)
                      && (cnt_ff == CHANNELS);
   assign is_chan   = (width_ff > cfg.pulse_min) && (width_ff < cfg.pulse_max)
                      && (cnt_ff < CHANNELS);
   assign below_low = width_ff < cfg.scale_low;
   assign above_top = {1'b0, width_ff} > scale_top;
   assign err_inc   = (err_ff == ERR_MAX) ? err_ff : err_ff + 8'd1;
   assign force_idle = res_ff.force_raw <= FORCE_IDLE_MAX;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_data_in           = res_ff;
      rsp_data_in.link_ok   = link_ff;
      rsp_data_in.motors_on = motor_ff;
   end

   // Safety reads go to the bank being filled, stick reads to the bank being shown.
   always_comb begin
      mem_req.rd_en   = (state_ff == ST_SAFE_RD) || (state_ff == ST_STICK_RD);
      mem_req.rd_addr = (state_ff == ST_STICK_RD) ? {bank_ff, k_ff} : {~bank_ff, k_ff};
      mem_req.wr_en   = state_ff == ST_WRITE;
      mem_req.wr_addr = {~bank_ff, cnt_ff};
      mem_req.wr_data = val_ff;
   end

   // (d << 8) - d is d * 255.
   assign div_req.start   = state_ff == ST_SCALE;
   assign div_req.num     = {d_ff, 8'd0} - {8'd0, d_ff};
   assign div_req.divisor = cfg.scale_span;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         cnt_ff       <= '0;
         err_ff       <= '0;
         link_ff      <= 1'b0;
         motor_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop valid once taken, unless a new word is loaded in the same cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  type_ff  <= req_type;
                  width_ff <= req_width;
                  res_ff   <= '0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (type_ff == REQ_POLL) begin
                  res_ff.pitch_raw <= STICK_CENTER;
                  res_ff.roll_raw  <= STICK_CENTER;
                  res_ff.force_raw <= FORCE_FALLBACK;
                  res_ff.yaw_raw   <= STICK_CENTER;
                  k_ff             <= SAFE_FIRST;
                  state_ff         <= link_ff ? ST_SAFE_RD : ST_MOTOR;
               end else if (is_sync) begin
                  k_ff     <= SAFE_FIRST;
                  state_ff <= ST_SAFE_RD;
               end else if (is_chan) begin
                  if (below_low) begin
                     val_ff   <= 8'd0;
                     state_ff <= ST_WRITE;
                  end else if (above_top) begin
                     val_ff   <= VALUE_MAX;
                     state_ff <= ST_WRITE;
                  end else if (cfg.scale_span == 16'd0) begin
                     val_ff   <= 8'd0;
                     state_ff <= ST_WRITE;
                  end else begin
                     d_ff     <= width_ff - cfg.scale_low;
                     state_ff <= ST_SCALE;
                  end
               end else begin
                  // restart the frame and count the error; past the error limit drop the link and beep
                  err_ff <= err_inc;
                  cnt_ff <= '0;
                  if (err_inc > cfg.error_limit) begin
                     link_ff     <= 1'b0;
                     res_ff.beep <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  val_ff   <= div_rsp.quot;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               res_ff.channel_index <= cnt_ff;
               res_ff.channel_value <= val_ff;
               res_ff.value_written <= 1'b1;
               cnt_ff               <= cnt_ff + 4'd1;
               state_ff             <= ST_DONE;
            end
            ST_SAFE_RD: begin
               state_ff <= ST_SAFE_CHK;
            end
            ST_SAFE_CHK: begin
               if (mem_rd_data >= cfg.fail_level) begin
                  if (type_ff == REQ_POLL) begin
                     state_ff <= ST_MOTOR;
                  end else begin
                     link_ff     <= 1'b0;
                     res_ff.beep <= 1'b1;
                     state_ff    <= ST_DONE;
                  end
               end else if (k_ff == SAFE_LAST) begin
                  if (type_ff == REQ_POLL) begin
                     k_ff     <= '0;
                     state_ff <= ST_STICK_RD;
                  end else begin
                     // accept the frame: swap banks
                     bank_ff              <= ~bank_ff;
                     err_ff               <= '0;
                     cnt_ff               <= '0;
                     link_ff              <= 1'b1;
                     res_ff.frame_swapped <= 1'b1;
                     state_ff             <= ST_DONE;
                  end
               end else begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= ST_SAFE_RD;
               end
            end
            ST_STICK_RD: begin
               state_ff <= ST_STICK_CHK;
            end
            ST_STICK_CHK: begin
               case (k_ff[1:0])
                  STICK_PITCH: res_ff.pitch_raw <= mem_rd_data;
                  STICK_ROLL:  res_ff.roll_raw  <= mem_rd_data;
                  STICK_FORCE: res_ff.force_raw <= mem_rd_data;
                  STICK_YAW:   res_ff.yaw_raw   <= mem_rd_data;
                  default: ;
               endcase
               if (k_ff == STICK_LAST) begin
                  state_ff <= ST_MOTOR;
               end else begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= ST_STICK_RD;
               end
            end
            ST_MOTOR: begin
               if (link_ff && force_idle && (res_ff.yaw_raw <= YAW_ARM_MAX)) begin
                  motor_ff <= 1'b1;
               end else if (!link_ff || (force_idle && (res_ff.yaw_raw >= YAW_DISARM_MIN))) begin
                  motor_ff <= 1'b0;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= rsp_data_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### design/ppm_frame_decoder_top.sv
// An error pulse goes straight to the result and a clamped channel is written first;
// a sync makes up to five safety reads on the single bank RAM port, a scaled channel
// waits on the 8-step divider and a poll makes up to nine reads.
// One word at a time; the next word is taken while the previous result waits.
// Reset (synchronous) clears control state and the bank valid bits, so both banks
// read as zero at once; no clearing pass.
module ppm_frame_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pulse_width
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] channel_index, [11:4] channel_value, [12] value_written,
   // [13] frame_swapped, [14] link_ok, [15] beep, [23:16] pitch_raw,
   // [31:24] roll_raw, [39:32] force_raw, [47:40] yaw_raw, [48] motors_on,
   // [55:49] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ppmfd_pkg::*;

   cfg_type     cfg;
   rsp_type     rsp_data;
   mem_req_type mem_req;
   logic [7:0]  mem_rd_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_pready = 1'b1;

   ppmfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ppmfd_bank_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   ppmfd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ppmfd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser),
      .req_width   (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   assign rsp_tdata = {7'd0,
                       rsp_data.motors_on,
                       rsp_data.yaw_raw,
                       rsp_data.force_raw,
                       rsp_data.roll_raw,
                       rsp_data.pitch_raw,
                       rsp_data.beep,
                       rsp_data.link_ok,
                       rsp_data.frame_swapped,
                       rsp_data.value_written,
                       rsp_data.channel_value,
                       rsp_data.channel_index};

endmodule

### design/ppmfd_checker.sv
// Port-level checks for the PPM frame decoder, bound to the top level.
module ppmfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_swap_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[14] && !rsp_tdata[15] && !rsp_tdata[12])
      else $error("bank swap without good link or with alarm");

   a_beep_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> !rsp_tdata[14] && !rsp_tdata[12])
      else $error("alarm with link good or with a stored value");

endmodule

bind ppm_frame_decoder_top ppmfd_checker u_ppmfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/ppm_frame_decoder_top_tb.sv
// Testbench for ppm_frame_decoder_top: pulse and poll words checked against a software predictor.
module ppm_frame_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppmfd_pkg::*;

   typedef enum logic {WORD_PULSE = 1'b0, WORD_POLL = 1'b1} word_kind_type;

   typedef enum int {
      REG_SYNC_MIN, REG_SYNC_MAX, REG_PULSE_MIN, REG_PULSE_MAX,
      REG_SCALE_LOW, REG_SCALE_SPAN, REG_FAIL_LEVEL, REG_ERROR_LIMIT
   } csr_index_type;

   localparam int BANK_DEPTH        = 16;
   localparam int SAFETY_FIRST      = 4;
   localparam int SAFETY_LAST       = 8;
   localparam int STICK_CENTER      = 128;
   localparam int THROTTLE_IDLE_MAX = 5;
   localparam int YAW_ARM_MAX       = 45;
   localparam int YAW_DISARM_MIN    = 210;
   localparam int VALUE_MAX         = 255;
   localparam int ERROR_COUNT_MAX   = 255;
   localparam int MAX_REPORTS       = 10;
   localparam int CYCLE_LIMIT       = 500000;
   localparam int DRAIN_CYCLES      = 40;
   localparam int PHASE_WORDS       = 24;
   localparam int FLOOD_WORDS       = 300;

   class ppm_scoreboard;
      cfg_type     cfg;
      logic [7:0]  bank [2][BANK_DEPTH];
      logic        bank_sel;
      logic [3:0]  chan_count;
      logic [7:0]  err_count;
      logic        link_good;
      logic        motor_latch;
      rsp_type     expected [$];
      int unsigned failures;

      function new();
         cfg.sync_min    = SYNC_MIN_RST;
         cfg.sync_max    = SYNC_MAX_RST;
         cfg.pulse_min   = PULSE_MIN_RST;
         cfg.pulse_max   = PULSE_MAX_RST;
         cfg.scale_low   = SCALE_LOW_RST;
         cfg.scale_span  = SCALE_SPAN_RST;
         cfg.fail_level  = FAIL_LEVEL_RST;
         cfg.error_limit = ERROR_LIMIT_RST;
         foreach (bank[b, i]) bank[b][i] = '0;
         bank_sel    = 1'b0;
         chan_count  = '0;
         err_count   = '0;
         link_good   = 1'b0;
         motor_latch = 1'b0;
         failures    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            REG_SYNC_MIN:    cfg.sync_min    = v[15:0];
            REG_SYNC_MAX:    cfg.sync_max    = v[15:0];
            REG_PULSE_MIN:   cfg.pulse_min   = v[15:0];
            REG_PULSE_MAX:   cfg.pulse_max   = v[15:0];
            REG_SCALE_LOW:   cfg.scale_low   = v[15:0];
            REG_SCALE_SPAN:  cfg.scale_span  = v[15:0];
            REG_FAIL_LEVEL:  cfg.fail_level  = v[7:0];
            REG_ERROR_LIMIT: cfg.error_limit = v[7:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] scale(logic [15:0] pw);
         int unsigned top;
         top = 32'(cfg.scale_low) + 32'(cfg.scale_span);
         if (pw < cfg.scale_low) return '0;
         if (32'(pw) > top) return 8'(VALUE_MAX);
         if (cfg.scale_span == '0) return '0;
         return 8'(((32'(pw) - 32'(cfg.scale_low)) * 32'(VALUE_MAX)) / 32'(cfg.scale_span));
      endfunction

      // Safety channels live in the bank currently being filled.
      function bit safety_clear();
         for (int i = SAFETY_FIRST; i <= SAFETY_LAST; i++)
            if (bank[~bank_sel][i] >= cfg.fail_level) return 1'b0;
         return 1'b1;
      endfunction

      function void note_word(word_kind_type kind, logic [15:0] pw);
         rsp_type    r;
         logic [7:0] v, pitch, roll, throttle, yaw;
         logic       wsel;
         r = '0;
         if (kind == WORD_PULSE) begin
            if (pw > cfg.sync_min && pw < cfg.sync_max && chan_count == CHANNELS) begin
               if (safety_clear()) begin
                  bank_sel = ~bank_sel;
                  err_count = '0;
                  chan_count = '0;
                  link_good = 1'b1;
                  r.frame_swapped = 1'b1;
               end else begin
                  link_good = 1'b0;
                  r.beep = 1'b1;
               end
            end else if (pw > cfg.pulse_min && pw < cfg.pulse_max && chan_count < CHANNELS) begin
               v = scale(pw);
               wsel = ~bank_sel;
               bank[wsel][chan_count] = v;
               r.channel_index = chan_count;
               r.channel_value = v;
               r.value_written = 1'b1;
               chan_count = chan_count + 4'd1;
            end else begin
               if (err_count != 8'(ERROR_COUNT_MAX)) err_count = err_count + 8'd1;
               chan_count = '0;
               if (err_count > cfg.error_limit) begin
                  link_good = 1'b0;
                  r.beep = 1'b1;
               end
            end
         end else begin
            pitch = 8'(STICK_CENTER);
            roll = 8'(STICK_CENTER);
            throttle = '0;
            yaw = 8'(STICK_CENTER);
            if (link_good && safety_clear()) begin
               pitch = bank[bank_sel][0];
               roll = bank[bank_sel][1];
               throttle = bank[bank_sel][2];
               yaw = bank[bank_sel][3];
            end
            if (link_good && throttle <= THROTTLE_IDLE_MAX && yaw <= YAW_ARM_MAX)
               motor_latch = 1'b1;
            else if (!link_good || (throttle <= THROTTLE_IDLE_MAX && yaw >= YAW_DISARM_MIN))
               motor_latch = 1'b0;
            r.pitch_raw = pitch;
            r.roll_raw = roll;
            r.force_raw = throttle;
            r.yaw_raw = yaw;
         end
         r.link_ok = link_good;
         r.motors_on = motor_latch;
         expected.push_back(r);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void cmp(string name, logic [7:0] exp_v, logic [7:0] got_v, inout string diff);
         if (got_v !== exp_v)
            diff = {diff, $sformatf(" %s exp %0d got %0d", name, exp_v, got_v)};
      endfunction

      function void check_word(logic [55:0] d);
         rsp_type want;
         string   diff;
         if (expected.size() == 0) begin
            flag($sformatf("result word %h with nothing expected", d));
            return;
         end
         want = expected.pop_front();
         diff = "";
         cmp("channel_index", 8'(want.channel_index), 8'(d[3:0]), diff);
         cmp("channel_value", want.channel_value, d[11:4], diff);
         cmp("value_written", 8'(want.value_written), 8'(d[12]), diff);
         cmp("frame_swapped", 8'(want.frame_swapped), 8'(d[13]), diff);
         cmp("link_ok", 8'(want.link_ok), 8'(d[14]), diff);
         cmp("beep", 8'(want.beep), 8'(d[15]), diff);
         cmp("pitch_raw", want.pitch_raw, d[23:16], diff);
         cmp("roll_raw", want.roll_raw, d[31:24], diff);
         cmp("force_raw", want.force_raw, d[39:32], diff);
         cmp("yaw_raw", want.yaw_raw, d[47:40], diff);
         cmp("motors_on", 8'(want.motors_on), 8'(d[48]), diff);
         if (diff != "") flag({"result word", diff});
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] pulse_width
   logic        req_tuser = 1'b0; // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] channel_index, [11:4] channel_value, [12] value_written, [13] frame_swapped,
   // [14] link_ok, [15] beep, [23:16] pitch_raw, [31:24] roll_raw, [39:32] force_raw,
   // [47:40] yaw_raw, [48] motors_on, [55:49] zero
   logic [55:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ppm_scoreboard sb = new();
   int  words_sent = 0;
   int  stall_left = 0;
   bit  tx_steady = 1'b0;
   bit  rx_steady = 1'b0;

   ppm_frame_decoder_top uut (.*);

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Take result words with random stalls; check each against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         if (stall_left > 0 && !rx_steady) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = 0;
            if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ppm_frame_decoder_top test failed");
      $finish;
   end

   // Valid stays high between back-to-back words so it never gets two updates in one step.
   task automatic push_word(word_kind_type kind, logic [15:0] pw);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= pw;
      do @(posedge clock); while (!req_tready);
      sb.note_word(kind, pw);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [15:0] v);
      logic [31:0] data;
      data = {16'($urandom), v};
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(int'(idx) * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, data);
   endtask

   task automatic apply_settings(logic [15:0] smin, logic [15:0] smax, logic [15:0] pmin,
                                 logic [15:0] pmax, logic [15:0] slow, logic [15:0] sspan,
                                 logic [7:0] fail, logic [7:0] elim);
      csr_write(REG_SYNC_MIN, smin);
      csr_write(REG_SYNC_MAX, smax);
      csr_write(REG_PULSE_MIN, pmin);
      csr_write(REG_PULSE_MAX, pmax);
      csr_write(REG_SCALE_LOW, slow);
      csr_write(REG_SCALE_SPAN, sspan);
      csr_write(REG_FAIL_LEVEL, 16'(fail));
      csr_write(REG_ERROR_LIMIT, 16'(elim));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_settings();
      int smin;
      smin = $urandom_range(2200, 6000);
      apply_settings(16'(smin), 16'(smin + $urandom_range(2, 20000)),
                     16'($urandom_range(0, 1100)), 16'($urandom_range(1800, 3000)),
                     16'($urandom_range(800, 1400)), 16'($urandom_range(1, 1200)),
                     8'($urandom_range(60, 255)), 8'($urandom_range(0, 20)));
   endtask

   function automatic logic [15:0] width_between(int unsigned lo, int unsigned hi);
      return 16'($urandom_range(hi - 1, lo + 1));
   endfunction

   // Bias widths toward the clamp edges so stick and safety thresholds get hit.
   function automatic logic [15:0] channel_width(bit safety);
      int lo, hi, sl, sp, w, mode;
      lo = sb.cfg.pulse_min;
      hi = sb.cfg.pulse_max;
      sl = sb.cfg.scale_low;
      sp = sb.cfg.scale_span;
      mode = (safety && $urandom_range(0, 4) != 0) ? 0 : $urandom_range(0, 3);
      case (mode)
         0: w = sl + int'($urandom_range(0, sp / 40));
         1: w = sl + sp - int'($urandom_range(0, sp / 40));
         2: w = sl - int'($urandom_range(0, 40));
         default: w = int'(width_between(lo, hi));
      endcase
      if (w <= lo || w >= hi) w = int'(width_between(lo, hi));
      return 16'(w);
   endfunction

   task automatic send_frame(bit complete);
      int n;
      n = complete ? int'(CHANNELS) : $urandom_range(0, int'(CHANNELS) - 1);
      for (int ch = 0; ch < n; ch++) begin
         push_word(WORD_PULSE, channel_width(ch >= SAFETY_FIRST));
         if ($urandom_range(0, 19) == 0) push_word(WORD_POLL, 16'($urandom));
      end
      // Occasionally overrun the frame with one channel too many.
      if (complete && $urandom_range(0, 7) == 0)
         push_word(WORD_PULSE, channel_width(1'b0));
      else
         push_word(WORD_PULSE, width_between(sb.cfg.sync_min, sb.cfg.sync_max));
      if ($urandom_range(0, 1) == 0) push_word(WORD_POLL, 16'($urandom));
   endtask

   task automatic run_phase(int words);
      int stop, r;
      stop = words_sent + words;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 60) send_frame(1'b1);
         else if (r < 75) push_word(WORD_POLL, 16'($urandom));
         else if (r < 88) push_word(WORD_PULSE, 16'($urandom));
         else send_frame(1'b0);
      end
      wait_idle();
   endtask

   initial begin : stimulus
      logic [16:0] script [26] = '{
         {WORD_POLL, 16'hFFFF}, {WORD_PULSE, 16'd0}, {WORD_PULSE, 16'hFFFF},
         {WORD_PULSE, 16'd900},
         {WORD_PULSE, 16'd901}, {WORD_PULSE, 16'd2099}, {WORD_PULSE, 16'd1100},
         {WORD_PULSE, 16'd1900}, {WORD_PULSE, 16'd1500}, {WORD_PULSE, 16'd1150},
         {WORD_PULSE, 16'd1150}, {WORD_PULSE, 16'd1150}, {WORD_PULSE, 16'd1150},
         {WORD_PULSE, 16'd3501}, {WORD_POLL, 16'd0},
         {WORD_PULSE, 16'd1500}, {WORD_PULSE, 16'd1500}, {WORD_PULSE, 16'd1100},
         {WORD_PULSE, 16'd1110}, {WORD_PULSE, 16'd1700}, {WORD_PULSE, 16'd1150},
         {WORD_PULSE, 16'd1150}, {WORD_PULSE, 16'd1150}, {WORD_PULSE, 16'd1150},
         {WORD_PULSE, 16'd13499}, {WORD_POLL, 16'h5A5A}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: boundaries, a good frame, a frame failing the safety check.
      foreach (script[i]) push_word(word_kind_type'(script[i][16]), script[i][15:0]);
      wait_idle();

      // Long error run so the error count has to saturate rather than wrap.
      apply_settings(SYNC_MIN_RST, SYNC_MAX_RST, PULSE_MIN_RST, PULSE_MAX_RST,
                     SCALE_LOW_RST, SCALE_SPAN_RST, FAIL_LEVEL_RST, 8'd254);
      tx_steady = 1'b1;
      repeat (FLOOD_WORDS) push_word(WORD_PULSE, 16'($urandom));
      wait_idle();

      apply_settings(SYNC_MIN_RST, SYNC_MAX_RST, PULSE_MIN_RST, PULSE_MAX_RST,
                     SCALE_LOW_RST, SCALE_SPAN_RST, FAIL_LEVEL_RST, ERROR_LIMIT_RST);
      run_phase(PHASE_WORDS);
      apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'hFF, 8'hFF);
      run_phase(PHASE_WORDS);
      // Zero span, every safety check fails, any error drops the link.
      apply_settings(SYNC_MIN_RST, SYNC_MAX_RST, PULSE_MIN_RST, PULSE_MAX_RST,
                     SCALE_LOW_RST, 16'd0, 8'd0, 8'd0);
      run_phase(PHASE_WORDS);
      random_settings();
      run_phase(PHASE_WORDS);
      apply_settings(SYNC_MIN_RST, SYNC_MAX_RST, PULSE_MIN_RST, PULSE_MAX_RST,
                     16'd1500, 16'd1, FAIL_LEVEL_RST, ERROR_LIMIT_RST);
      run_phase(PHASE_WORDS);
      random_settings();
      run_phase(PHASE_WORDS);
      random_settings();
      run_phase(PHASE_WORDS);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
      if (sb.failures == 0)
         $display("ppm_frame_decoder_top test passed");
      else
         $display("ppm_frame_decoder_top test failed");
      $finish;
   end

endmodule
